### rtl/sdwp_pkg.sv
// Shared types and constants for the shake detector with weighted pick.
// Used by sdwp_csr, sdwp_filter, sdwp_moddiv and the top level.
package sdwp_pkg;

   // Field widths
   localparam int SAMPLE_W  = 16;
   localparam int AMP_W     = 17;
   localparam int THR_W     = 16;
   localparam int SCORE_W   = 4;
   localparam int COUNT_W   = 8;
   localparam int WEIGHTS_W = 56;
   localparam int WEIGHT_W  = 8;
   localparam int RNG_W     = 32;
   localparam int PICK_W    = 3;
   localparam int PHASE_W   = 2;
   localparam int DIR_W     = 2;

   // Configuration bus
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = 3;

   // Default number of lots in the pick
   localparam int LOT_COUNT_DEF = 7;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_SHAKE_THR  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_STRONG_THR = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_QUIET_THR  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_START      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MAX        = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_STOP_QUIET = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_WARMUP     = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_WEIGHTS    = 3'd7;

   // Register reset values
   localparam logic [THR_W-1:0]     RST_SHAKE_THR  = 16'd180;
   localparam logic [THR_W-1:0]     RST_STRONG_THR = 16'd350;
   localparam logic [THR_W-1:0]     RST_QUIET_THR  = 16'd90;
   localparam logic [SCORE_W-1:0]   RST_START      = 4'd3;
   localparam logic [SCORE_W-1:0]   RST_MAX        = 4'd8;
   localparam logic [COUNT_W-1:0]   RST_STOP_QUIET = 8'd8;
   localparam logic [COUNT_W-1:0]   RST_WARMUP     = 8'd8;
   localparam logic [WEIGHTS_W-1:0] RST_WEIGHTS    = 56'd285916276528660;

   // Random generator seed, also used in place of an all-zero state
   localparam logic [RNG_W-1:0] RNG_SEED = 32'h2545F491;

   // Phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
   localparam logic [PHASE_W-1:0] PH_SHAKE  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_RESULT = 2'd2;

   // Dominant-axis direction codes
   localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_POS  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_NEG  = 2'd2;

   typedef struct packed {
      logic [THR_W-1:0]     shake_thr;
      logic [THR_W-1:0]     strong_thr;
      logic [THR_W-1:0]     quiet_thr;
      logic [SCORE_W-1:0]   start_score;
      logic [SCORE_W-1:0]   max_score;
      logic [COUNT_W-1:0]   stop_quiet;
      logic [COUNT_W-1:0]   warmup;
      logic [WEIGHTS_W-1:0] weights;
   } cfg_type;

   typedef struct packed {
      logic grav_en;
      logic resid_en;
   } filt_ctrl_type;

   typedef struct packed {
      logic             seeded;
      logic [AMP_W-1:0] amp;
      logic             proj_neg;
   } filt_stat_type;

endpackage

### rtl/sdwp_csr.sv
// Configuration register file with an APB-style slave port.
// Depends on sdwp_pkg for register indexes, reset values and cfg_type.
module sdwp_csr
   import sdwp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type                cfg_ff;
   logic                   wr_en;
   logic [REG_IDX_W-1:0]   reg_idx;

   // Registers sit on 8-byte boundaries
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shake_thr   <= RST_SHAKE_THR;
         cfg_ff.strong_thr  <= RST_STRONG_THR;
         cfg_ff.quiet_thr   <= RST_QUIET_THR;
         cfg_ff.start_score <= RST_START;
         cfg_ff.max_score   <= RST_MAX;
         cfg_ff.stop_quiet  <= RST_STOP_QUIET;
         cfg_ff.warmup      <= RST_WARMUP;
         cfg_ff.weights     <= RST_WEIGHTS;
      end else if (wr_en) begin
         case (reg_idx)
            REG_SHAKE_THR:  cfg_ff.shake_thr   <= csr_pwdata[THR_W-1:0];
            REG_STRONG_THR: cfg_ff.strong_thr  <= csr_pwdata[THR_W-1:0];
            REG_QUIET_THR:  cfg_ff.quiet_thr   <= csr_pwdata[THR_W-1:0];
            REG_START:      cfg_ff.start_score <= csr_pwdata[SCORE_W-1:0];
            REG_MAX:        cfg_ff.max_score   <= csr_pwdata[SCORE_W-1:0];
            REG_STOP_QUIET: cfg_ff.stop_quiet  <= csr_pwdata[COUNT_W-1:0];
            REG_WARMUP:     cfg_ff.warmup      <= csr_pwdata[COUNT_W-1:0];
            REG_WEIGHTS:    cfg_ff.weights     <= csr_pwdata[WEIGHTS_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register, zero extended
   always_comb begin
      case (reg_idx)
         REG_SHAKE_THR:  csr_prdata = CSR_DATA_W'(cfg_ff.shake_thr);
         REG_STRONG_THR: csr_prdata = CSR_DATA_W'(cfg_ff.strong_thr);
         REG_QUIET_THR:  csr_prdata = CSR_DATA_W'(cfg_ff.quiet_thr);
         REG_START:      csr_prdata = CSR_DATA_W'(cfg_ff.start_score);
         REG_MAX:        csr_prdata = CSR_DATA_W'(cfg_ff.max_score);
         REG_STOP_QUIET: csr_prdata = CSR_DATA_W'(cfg_ff.stop_quiet);
         REG_WARMUP:     csr_prdata = CSR_DATA_W'(cfg_ff.warmup);
         REG_WEIGHTS:    csr_prdata = CSR_DATA_W'(cfg_ff.weights);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

### rtl/sdwp_filter.sv
// Gravity tracking filter for X/Y and residual amplitude / direction.
// Depends on sdwp_pkg for widths and the filter control/status structs.
module sdwp_filter
   import sdwp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  filt_ctrl_type              ctrl,
   input  logic signed [SAMPLE_W-1:0] accel_x,
   input  logic signed [SAMPLE_W-1:0] accel_y,
   output filt_stat_type              stat
);

   logic                       seeded_ff;
   logic signed [SAMPLE_W-1:0] grav_x_ff, grav_y_ff, grav_x_in, grav_y_in;
   logic [AMP_W-1:0]           amp_ff, amp_in;
   logic                       proj_neg_ff, proj_neg_in;

   logic signed [SAMPLE_W:0]   dx, dy, lx, ly, ax, ay;
   logic signed [SAMPLE_W:0]   qx, qy;

   // Step the estimate by diff/8, truncated toward zero
   assign dx = 17'(accel_x) - 17'(grav_x_ff);
   assign dy = 17'(accel_y) - 17'(grav_y_ff);
   assign qx = (dx[SAMPLE_W] ? dx + 17'sd7 : dx) >>> 3;
   assign qy = (dy[SAMPLE_W] ? dy + 17'sd7 : dy) >>> 3;
   assign grav_x_in = SAMPLE_W'(17'(grav_x_ff) + qx);
   assign grav_y_in = SAMPLE_W'(17'(grav_y_ff) + qy);

   // Residuals against the updated estimate
   assign lx = 17'(accel_x) - 17'(grav_x_ff);
   assign ly = 17'(accel_y) - 17'(grav_y_ff);
   assign ax = lx[SAMPLE_W] ? -lx : lx;
   assign ay = ly[SAMPLE_W] ? -ly : ly;
   assign amp_in      = AMP_W'(ax) + AMP_W'(ay);
   assign proj_neg_in = (ax >= ay) ? lx[SAMPLE_W] : ly[SAMPLE_W];

   // Seed, then track gravity
   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
      end else if (ctrl.grav_en) begin
         seeded_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.grav_en) begin
         if (!seeded_ff) begin
            grav_x_ff <= accel_x;
            grav_y_ff <= accel_y;
         end else begin
            grav_x_ff <= grav_x_in;
            grav_y_ff <= grav_y_in;
         end
      end
      if (ctrl.resid_en) begin
         amp_ff      <= amp_in;
         proj_neg_ff <= proj_neg_in;
      end
   end

   assign stat.seeded   = seeded_ff;
   assign stat.amp      = amp_ff;
   assign stat.proj_neg = proj_neg_ff;

endmodule

### rtl/sdwp_moddiv.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on sdwp_pkg for the dividend width.
module sdwp_moddiv
   import sdwp_pkg::*;
#(
   parameter int DIV_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RNG_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] remainder
);

   localparam int BIT_CNT_W = $clog2(RNG_W);
   localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(RNG_W - 1);

   logic                 busy_ff, done_ff;
   logic [BIT_CNT_W-1:0] bit_cnt_ff;
   logic [RNG_W-1:0]     quo_ff;
   logic [DIV_W-1:0]     rem_ff, dvs_ff, rem_in;
   logic [DIV_W:0]       trial;

   // Shift in the next dividend bit and subtract when it fits
   assign trial  = {rem_ff, quo_ff[RNG_W-1]};
   assign rem_in = (trial >= {1'b0, dvs_ff}) ? DIV_W'(trial - {1'b0, dvs_ff})
                                             : trial[DIV_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_cnt_ff == LAST_BIT) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         dvs_ff     <= divisor;
         rem_ff     <= '0;
         bit_cnt_ff <= '0;
      end else if (busy_ff) begin
         quo_ff     <= {quo_ff[RNG_W-2:0], 1'b0};
         rem_ff     <= rem_in;
         bit_cnt_ff <= bit_cnt_ff + 1'b1;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < dvs_ff)
      else $error("remainder not below divisor");

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule

### rtl/shake_detect_weighted_pick_top.sv
// Top level of the shake detector with weighted random pick.
// Depends on sdwp_pkg, sdwp_csr, sdwp_filter and sdwp_moddiv.
//
// Usage: each accelerometer word (req_accel_x/y/z) is offered on the req_
// channel with valid/ready and yields exactly one rsp_ word carrying the
// phase, the shaking flag, the score and, when shaking ends, a pick index.
// req_ready is high only while the sequencer waits for a new word; a word
// is taken at the edge where req_valid and req_ready are both high.
// An ordinary sample passes through the gravity step, residual, scoring and
// output load in that order; a new word is taken only after the load.
// A sample that ends shaking also sums the weights, steps the random
// generator, runs the 32-step remainder unit and scans the cumulative
// weights; when all weights are zero it skips the generator step, the
// remainder unit and the scan and picks lot 0.
// One word is in flight at a time. The output register holds a finished
// word while rsp_ready is low; the next word may already be accepted and
// processed, and it waits in the output stage until the previous is taken.
// Reset (synchronous, active high) restores register defaults, clears the
// seed flag, scores and phase, and reloads the random state.
// Registers are written through the csr_ port, 8 bytes apart.
module shake_detect_weighted_pick_top
   import sdwp_pkg::*;
#(
   parameter int LOT_COUNT = LOT_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_accel_x,
   input  logic signed [SAMPLE_W-1:0] req_accel_y,
   input  logic signed [SAMPLE_W-1:0] req_accel_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [PHASE_W-1:0]         rsp_phase_now,
   output logic                       rsp_is_shaking,
   output logic                       rsp_pick_valid,
   output logic [PICK_W-1:0]          rsp_pick_index,
   output logic [SCORE_W-1:0]         rsp_score_now,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [CSR_DATA_W-1:0]      csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int TOT_W = $clog2(LOT_COUNT * 255 + 1);
   localparam logic [PICK_W-1:0] LAST_LOT = PICK_W'(LOT_COUNT - 1);
   localparam int NUM_WEIGHTS = WEIGHTS_W / WEIGHT_W;
   localparam logic [RNG_W-1:0] MIX_X_MUL = 32'd31;
   localparam logic [RNG_W-1:0] MIX_Y_MUL = 32'd17;

   // Sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_GRAV  = 4'd1;
   localparam logic [3:0] S_RESID = 4'd2;
   localparam logic [3:0] S_SCORE = 4'd3;
   localparam logic [3:0] S_SUM   = 4'd4;
   localparam logic [3:0] S_RAND  = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_SRCH  = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   // Sample handling modes
   localparam logic [1:0] MODE_SEED  = 2'd0;
   localparam logic [1:0] MODE_WARM  = 2'd1;
   localparam logic [1:0] MODE_SCORE = 2'd2;

   function automatic logic [WEIGHT_W-1:0] weight_of(input logic [WEIGHTS_W-1:0] w,
                                                    input logic [PICK_W-1:0] i);
      if (int'(i) < NUM_WEIGHTS) begin
         return w[WEIGHT_W*i +: WEIGHT_W];
      end
      return '0;
   endfunction

   function automatic logic [RNG_W-1:0] xorshift_next(input logic [RNG_W-1:0] v);
      logic [RNG_W-1:0] s;
      s = (v != '0) ? v : RNG_SEED;
      s = s ^ (s << 13);
      s = s ^ (s >> 17);
      s = s ^ (s << 5);
      return s;
   endfunction

   cfg_type        cfg;
   filt_ctrl_type  filt_ctrl;
   filt_stat_type  filt_stat;

   logic [3:0]                 state_ff, state_in;
   logic signed [SAMPLE_W-1:0] sx_ff, sy_ff, sz_ff;
   logic [1:0]                 mode_ff, mode_in;
   logic [COUNT_W-1:0]         warm_cnt_ff, warm_cnt_in;
   logic [RNG_W-1:0]           rng_ff, rng_in, rng_mixed, rng_step;
   logic [SCORE_W-1:0]         rev_ff, rev_in;
   logic [DIR_W-1:0]           dir_ff, dir_in, dir_cur;
   logic [COUNT_W-1:0]         quiet_ff, quiet_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic                       shaking_ff, shaking_in;
   logic                       pick_ff, pick_in;
   logic [PICK_W-1:0]          idx_ff, idx_in;
   logic [PICK_W-1:0]          cnt_ff, cnt_in;
   logic [TOT_W-1:0]           total_ff, total_in;
   logic [TOT_W-1:0]           acc_ff, acc_in;
   logic [SCORE_W:0]           rev_sum;
   logic                       amp_quiet, amp_shake, amp_strong;
   logic [WEIGHT_W-1:0]        cur_weight;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0]         rsp_phase_ff;
   logic                       rsp_shaking_ff, rsp_pick_ff;
   logic [PICK_W-1:0]          rsp_idx_ff;
   logic [SCORE_W-1:0]         rsp_score_ff;
   logic                       rsp_load;

   logic                       div_start, div_done;
   logic [TOT_W-1:0]           div_rem;

   sdwp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sdwp_filter u_filter (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (filt_ctrl),
      .accel_x (sx_ff),
      .accel_y (sy_ff),
      .stat    (filt_stat)
   );

   sdwp_moddiv #(
      .DIV_W (TOT_W)
   ) u_moddiv (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rng_in),
      .divisor   (total_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // Random mixing of the raw axes (zero extended) and the xorshift step
   assign rng_mixed = rng_ff ^ ({16'h0000, sx_ff} * MIX_X_MUL)
                             ^ ({16'h0000, sy_ff} * MIX_Y_MUL)
                             ^ {16'h0000, sz_ff}
                             ^ (rng_ff << 1);
   assign rng_step  = xorshift_next(rng_ff);

   // Amplitude compares
   assign amp_quiet  = filt_stat.amp < AMP_W'(cfg.quiet_thr);
   assign amp_shake  = filt_stat.amp > AMP_W'(cfg.shake_thr);
   assign amp_strong = filt_stat.amp > AMP_W'(cfg.strong_thr);
   assign dir_cur    = filt_stat.proj_neg ? DIR_NEG : DIR_POS;
   assign rev_sum    = {1'b0, rev_ff} + (amp_strong ? 5'd2 : 5'd1);

   assign cur_weight = weight_of(cfg.weights, cnt_ff);

   assign filt_ctrl.grav_en  = (state_ff == S_GRAV);
   assign filt_ctrl.resid_en = (state_ff == S_RESID);
   assign div_start          = (state_ff == S_RAND) && (total_ff != '0);
   assign rsp_load           = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      warm_cnt_in = warm_cnt_ff;
      rng_in      = rng_ff;
      rev_in      = rev_ff;
      dir_in      = dir_ff;
      quiet_in    = quiet_ff;
      phase_in    = phase_ff;
      shaking_in  = shaking_ff;
      pick_in     = pick_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      total_in    = total_ff;
      acc_in      = acc_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_GRAV;
            end
         end
         S_GRAV: begin
            // Classify the sample, mix entropy, count warm-up
            if (!filt_stat.seeded) begin
               mode_in = MODE_SEED;
            end else begin
               rng_in = rng_mixed;
               if (warm_cnt_ff < cfg.warmup) begin
                  mode_in     = MODE_WARM;
                  warm_cnt_in = warm_cnt_ff + 1'b1;
               end else begin
                  mode_in = MODE_SCORE;
               end
            end
            state_in = S_RESID;
         end
         S_RESID: begin
            state_in = S_SCORE;
         end
         S_SCORE: begin
            // Quiet run, reversal score and direction
            shaking_in = 1'b0;
            pick_in    = 1'b0;
            idx_in     = '0;
            if (mode_ff == MODE_SCORE) begin
               if (amp_quiet) begin
                  if (quiet_ff != '1) begin
                     quiet_in = quiet_ff + 1'b1;
                  end
               end else begin
                  quiet_in = '0;
               end
               if (amp_shake) begin
                  if (dir_ff != DIR_NONE && dir_cur != dir_ff) begin
                     rev_in = (rev_sum > {1'b0, cfg.max_score}) ? cfg.max_score
                                                                 : rev_sum[SCORE_W-1:0];
                  end
                  dir_in = dir_cur;
               end else if (amp_quiet) begin
                  if (rev_ff != '0) begin
                     rev_in = rev_ff - 1'b1;
                  end
                  dir_in = DIR_NONE;
               end
               shaking_in = (rev_in >= cfg.start_score);
            end
            // Phase control
            state_in = S_OUT;
            case (phase_ff)
               PH_IDLE, PH_RESULT: begin
                  if (shaking_in) begin
                     quiet_in = '0;
                     phase_in = PH_SHAKE;
                  end
               end
               PH_SHAKE: begin
                  if (quiet_in >= cfg.stop_quiet) begin
                     pick_in  = 1'b1;
                     rev_in   = '0;
                     dir_in   = DIR_NONE;
                     phase_in = PH_RESULT;
                     cnt_in   = '0;
                     total_in = '0;
                     state_in = S_SUM;
                  end
               end
               default: ;
            endcase
         end
         S_SUM: begin
            // Accumulate the weight total, one lot a cycle
            total_in = total_ff + TOT_W'(cur_weight);
            if (cnt_ff == LAST_LOT) begin
               state_in = S_RAND;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_RAND: begin
            // Zero total: pick lot 0 and leave the generator alone
            if (total_ff == '0) begin
               idx_in   = '0;
               state_in = S_OUT;
            end else begin
               rng_in   = rng_step;
               cnt_in   = '0;
               acc_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            // Scan cumulative weights for the drawn value
            acc_in = acc_ff + TOT_W'(cur_weight);
            if (div_rem < acc_in) begin
               idx_in   = cnt_ff;
               state_in = S_OUT;
            end else if (cnt_ff == LAST_LOT) begin
               idx_in   = LAST_LOT;
               state_in = S_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         warm_cnt_ff <= '0;
         rng_ff      <= RNG_SEED;
         rev_ff      <= '0;
         dir_ff      <= DIR_NONE;
         quiet_ff    <= '0;
         phase_ff    <= PH_IDLE;
      end else begin
         state_ff    <= state_in;
         warm_cnt_ff <= warm_cnt_in;
         rng_ff      <= rng_in;
         rev_ff      <= rev_in;
         dir_ff      <= dir_in;
         quiet_ff    <= quiet_in;
         phase_ff    <= phase_in;
      end
   end

   // Working registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sx_ff <= req_accel_x;
         sy_ff <= req_accel_y;
         sz_ff <= req_accel_z;
      end
      mode_ff    <= mode_in;
      shaking_ff <= shaking_in;
      pick_ff    <= pick_in;
      idx_ff     <= idx_in;
      cnt_ff     <= cnt_in;
      total_ff   <= total_in;
      acc_ff     <= acc_in;
   end

   // Output stage: hold the word until taken
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_phase_ff   <= phase_ff;
         rsp_shaking_ff <= shaking_ff;
         rsp_pick_ff    <= pick_ff;
         rsp_idx_ff     <= idx_ff;
         rsp_score_ff   <= rev_ff;
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_phase_now  = rsp_phase_ff;
   assign rsp_is_shaking = rsp_shaking_ff;
   assign rsp_pick_valid = rsp_pick_ff;
   assign rsp_pick_index = rsp_idx_ff;
   assign rsp_score_now  = rsp_score_ff;

   a_pick_in_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pick_ff |-> rsp_phase_ff == PH_RESULT && rsp_score_ff == '0)
      else $error("pick word outside result phase or with nonzero score");

   a_index_zero_no_pick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pick_ff |-> rsp_idx_ff == '0)
      else $error("index set without a pick");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while busy");

   a_load_once_per_word: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> state_ff == S_IDLE)
      else $error("sequencer did not return to idle after output load");

endmodule

### bench/shake_detect_weighted_pick_top_tb.sv
// Self-checking bench for shake_detect_weighted_pick_top: directed table, then shaped
// random motion under several register settings, scored by an in-bench predictor.
// Depends on sdwp_pkg and the top level only.
`timescale 1ns / 100ps

module shake_detect_weighted_pick_top_tb;
   import sdwp_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int LOTS           = LOT_COUNT_DEF;
   localparam int REG_COUNT      = 8;
   localparam int DIRECTED_COUNT = 25;

   // One result word as the block reports it
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               shaking;
      logic               pick_valid;
      logic [PICK_W-1:0]  pick_index;
      logic [SCORE_W-1:0] score;
   } shake_report_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] x;
      logic [SAMPLE_W-1:0] y;
      logic [SAMPLE_W-1:0] z;
      logic                typed;
      shake_report_type    want;
   } stim_row_type;

   typedef enum logic [1:0] {MOTION_SWING, MOTION_STILL, MOTION_DRIFT, MOTION_NOISE} motion_type;
   typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_CHOKE, SINK_LIGHT} sink_type;

   localparam shake_report_type ZERO_REPORT = '{PH_IDLE, 1'b0, 1'b0, 3'd0, 4'd0};

   // Seed and warm-up rows have a known all-zero report; the rest go to the predictor
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{16'h7FFF, 16'h8000, 16'h8000, 1'b1, ZERO_REPORT},  // seeds gravity
      '{16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, ZERO_REPORT},  // warm-up starts
      '{16'h0000, 16'h0000, 16'h0000, 1'b1, ZERO_REPORT},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, ZERO_REPORT},
      '{16'h7FFF, 16'h8000, 16'h0000, 1'b1, ZERO_REPORT},
      '{16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, ZERO_REPORT},
      '{16'h5555, 16'hAAAA, 16'h5555, 1'b1, ZERO_REPORT},
      '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, ZERO_REPORT},
      '{16'h0000, 16'h0000, 16'h0001, 1'b1, ZERO_REPORT},  // last warm-up word
      '{16'h0BB8, 16'h0000, 16'h7FFF, 1'b0, ZERO_REPORT},  // X reversals
      '{16'hF448, 16'h0000, 16'h8000, 1'b0, ZERO_REPORT},
      '{16'h0BB8, 16'h0064, 16'h0000, 1'b0, ZERO_REPORT},
      '{16'hF448, 16'hFF9C, 16'hFFFF, 1'b0, ZERO_REPORT},
      '{16'h0BB8, 16'h0000, 16'h1234, 1'b0, ZERO_REPORT},
      '{16'hF448, 16'h0000, 16'hEDCB, 1'b0, ZERO_REPORT},
      '{16'h0000, 16'h0BB8, 16'h0000, 1'b0, ZERO_REPORT},  // Y dominant
      '{16'h0000, 16'hF448, 16'h7FFF, 1'b0, ZERO_REPORT},
      '{16'h0000, 16'h0BB8, 16'h8000, 1'b0, ZERO_REPORT},
      '{16'h0096, 16'h0000, 16'h0000, 1'b0, ZERO_REPORT},
      '{16'h7FFF, 16'h8000, 16'h5555, 1'b0, ZERO_REPORT},  // largest residuals
      '{16'h8000, 16'h7FFF, 16'hAAAA, 1'b0, ZERO_REPORT},
      '{16'h0000, 16'h0000, 16'h0000, 1'b0, ZERO_REPORT},  // settle
      '{16'h0000, 16'h0000, 16'h0000, 1'b0, ZERO_REPORT},
      '{16'h0000, 16'h0000, 16'h0000, 1'b0, ZERO_REPORT},
      '{16'h0000, 16'h0000, 16'h0000, 1'b0, ZERO_REPORT}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_accel_x = '0;
   logic [SAMPLE_W-1:0]   req_accel_y = '0;
   logic [SAMPLE_W-1:0]   req_accel_z = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PHASE_W-1:0]    rsp_phase_now;
   logic                  rsp_is_shaking;
   logic                  rsp_pick_valid;
   logic [PICK_W-1:0]     rsp_pick_index;
   logic [SCORE_W-1:0]    rsp_score_now;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor copy of the block's registers and state
   cfg_type            model_cfg;
   logic               seeded_q;
   logic [COUNT_W-1:0] warm_q;
   int                 grav_x_q;
   int                 grav_y_q;
   logic [SCORE_W-1:0] score_q;
   logic [DIR_W-1:0]   dir_q;
   logic [COUNT_W-1:0] quiet_q;
   logic [PHASE_W-1:0] phase_q;
   logic [RNG_W-1:0]   rng_q;

   shake_report_type pending_reports [$];
   int               fail_count = 0;
   int unsigned      cycle_count = 0;

   // Sender pacing and motion shaping
   int         burst_left = 0;
   motion_type motion_mode = MOTION_STILL;
   int         motion_left = 0;
   int         swing_amp = 0;
   int         swing_sign = 1;
   logic       swing_on_y = 1'b0;
   int         base_x = 0;
   int         base_y = 0;

   // Receiver stall pattern
   sink_type sink_mode = SINK_OPEN;
   int       sink_hold = 0;

   shake_detect_weighted_pick_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_accel_x    (req_accel_x),
      .req_accel_y    (req_accel_y),
      .req_accel_z    (req_accel_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_phase_now  (rsp_phase_now),
      .rsp_is_shaking (rsp_is_shaking),
      .rsp_pick_valid (rsp_pick_valid),
      .rsp_pick_index (rsp_pick_index),
      .rsp_score_now  (rsp_score_now),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("shake_detect_weighted_pick_top_tb: FAIL");
         $finish;
      end
   end

   // Stall the result side: open, coin-flip, mostly blocked or lightly blocked stretches
   always @(posedge clock) begin
      if (sink_hold == 0) begin
         sink_mode <= sink_type'($urandom_range(0, 3));
         sink_hold <= $urandom_range(10, 200);
      end else begin
         sink_hold <= sink_hold - 1;
      end
      case (sink_mode)
         SINK_OPEN:  rsp_ready <= 1'b1;
         SINK_COIN:  rsp_ready <= ($urandom_range(0, 1) == 1);
         SINK_CHOKE: rsp_ready <= ($urandom_range(0, 7) == 0);
         default:    rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   function automatic void check_field(string name, logic [3:0] want_v, logic [3:0] got);
      if (got !== want_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got);
         fail_count++;
      end
   endfunction

   // Compare each accepted result word with the oldest pending report
   always @(posedge clock) begin : rsp_check
      shake_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected rsp word: phase_now %0d score_now %0d",
                   rsp_phase_now, rsp_score_now);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("phase_now", 4'(want.phase), 4'(rsp_phase_now));
            check_field("is_shaking", 4'(want.shaking), 4'(rsp_is_shaking));
            check_field("pick_valid", 4'(want.pick_valid), 4'(rsp_pick_valid));
            check_field("pick_index", 4'(want.pick_index), 4'(rsp_pick_index));
            check_field("score_now", 4'(want.score), 4'(rsp_score_now));
         end
      end
   end

   function automatic void reset_model();
      model_cfg = '{RST_SHAKE_THR, RST_STRONG_THR, RST_QUIET_THR, RST_START, RST_MAX,
                    RST_STOP_QUIET, RST_WARMUP, RST_WEIGHTS};
      seeded_q = 1'b0;
      warm_q   = '0;
      grav_x_q = 0;
      grav_y_q = 0;
      score_q  = '0;
      dir_q    = DIR_NONE;
      quiet_q  = '0;
      phase_q  = PH_IDLE;
      rng_q    = RNG_SEED;
   endfunction

   // Register value as the block holds it, zero-extended to the bus
   function automatic logic [CSR_DATA_W-1:0] cfg_field(cfg_type c, logic [REG_IDX_W-1:0] idx);
      case (idx)
         REG_SHAKE_THR:  return CSR_DATA_W'(c.shake_thr);
         REG_STRONG_THR: return CSR_DATA_W'(c.strong_thr);
         REG_QUIET_THR:  return CSR_DATA_W'(c.quiet_thr);
         REG_START:      return CSR_DATA_W'(c.start_score);
         REG_MAX:        return CSR_DATA_W'(c.max_score);
         REG_STOP_QUIET: return CSR_DATA_W'(c.stop_quiet);
         REG_WARMUP:     return CSR_DATA_W'(c.warmup);
         default:        return CSR_DATA_W'(c.weights);
      endcase
   endfunction

   function automatic void apply_register(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      case (idx)
         REG_SHAKE_THR:  model_cfg.shake_thr   = v[THR_W-1:0];
         REG_STRONG_THR: model_cfg.strong_thr  = v[THR_W-1:0];
         REG_QUIET_THR:  model_cfg.quiet_thr   = v[THR_W-1:0];
         REG_START:      model_cfg.start_score = v[SCORE_W-1:0];
         REG_MAX:        model_cfg.max_score   = v[SCORE_W-1:0];
         REG_STOP_QUIET: model_cfg.stop_quiet  = v[COUNT_W-1:0];
         REG_WARMUP:     model_cfg.warmup      = v[COUNT_W-1:0];
         default:        model_cfg.weights     = v[WEIGHTS_W-1:0];
      endcase
   endfunction

   // Weighted draw: step the xorshift, take it modulo the weight total, scan the lots
   function automatic logic [PICK_W-1:0] draw_lot();
      logic [RNG_W-1:0] total;
      logic [RNG_W-1:0] acc;
      logic [RNG_W-1:0] sel;
      logic [RNG_W-1:0] v;
      int               i;
      total = '0;
      for (i = 0; i < LOTS; i++)
         total += RNG_W'(model_cfg.weights[WEIGHT_W*i +: WEIGHT_W]);
      if (total == 0)
         return '0;
      v = (rng_q != 0) ? rng_q : RNG_SEED;
      v ^= v << 13;
      v ^= v >> 17;
      v ^= v << 5;
      rng_q = v;
      sel = v % total;
      acc = '0;
      for (i = 0; i < LOTS; i++) begin
         acc += RNG_W'(model_cfg.weights[WEIGHT_W*i +: WEIGHT_W]);
         if (sel < acc)
            return PICK_W'(i);
      end
      return PICK_W'(LOTS - 1);
   endfunction

   // Advance the predicted state by one sample and build its report
   function automatic shake_report_type score_and_pick(logic [SAMPLE_W-1:0] rx,
                                                        logic [SAMPLE_W-1:0] ry,
                                                        logic [SAMPLE_W-1:0] rz);
      shake_report_type rep;
      int               sx, sy, lx, ly, ax, ay, amp, proj, bumped;
      int               shake_lim, strong_lim, quiet_lim;
      logic [DIR_W-1:0] dir;
      logic             shaking;
      sx = int'(signed'(rx));
      sy = int'(signed'(ry));
      shake_lim  = int'(model_cfg.shake_thr);
      strong_lim = int'(model_cfg.strong_thr);
      quiet_lim  = int'(model_cfg.quiet_thr);
      shaking = 1'b0;
      rep = ZERO_REPORT;
      if (!seeded_q) begin
         grav_x_q = sx;
         grav_y_q = sy;
         seeded_q = 1'b1;
      end else begin
         // Track gravity, truncating toward zero
         grav_x_q += (sx - grav_x_q) / 8;
         grav_y_q += (sy - grav_y_q) / 8;
         lx = sx - grav_x_q;
         ly = sy - grav_y_q;
         ax = (lx < 0) ? -lx : lx;
         ay = (ly < 0) ? -ly : ly;
         amp = ax + ay;
         proj = (ax >= ay) ? lx : ly;
         rng_q = rng_q ^ ({16'h0, rx} * 32'd31) ^ ({16'h0, ry} * 32'd17) ^ {16'h0, rz}
                 ^ (rng_q << 1);
         if (warm_q < model_cfg.warmup) begin
            warm_q++;
         end else begin
            if (amp < quiet_lim) begin
               if (quiet_q != 8'hFF)
                  quiet_q++;
            end else begin
               quiet_q = '0;
            end
            // Reversal score with a dead band between the thresholds
            if (amp > shake_lim) begin
               dir = (proj >= 0) ? DIR_POS : DIR_NEG;
               if (dir_q != DIR_NONE && dir != dir_q) begin
                  bumped = int'(score_q) + ((amp > strong_lim) ? 2 : 1);
                  if (bumped > int'(model_cfg.max_score))
                     bumped = int'(model_cfg.max_score);
                  score_q = SCORE_W'(bumped);
               end
               dir_q = dir;
            end else if (amp < quiet_lim) begin
               if (score_q != 0)
                  score_q--;
               dir_q = DIR_NONE;
            end
            shaking = (score_q >= model_cfg.start_score);
         end
      end
      // Phase sequencing
      case (phase_q)
         PH_IDLE, PH_RESULT: begin
            if (shaking) begin
               quiet_q = '0;
               phase_q = PH_SHAKE;
            end
         end
         PH_SHAKE: begin
            if (quiet_q >= model_cfg.stop_quiet) begin
               rep.pick_index = draw_lot();
               rep.pick_valid = 1'b1;
               score_q = '0;
               dir_q = DIR_NONE;
               phase_q = PH_RESULT;
            end
         end
         default: ;
      endcase
      rep.phase   = phase_q;
      rep.shaking = shaking;
      rep.score   = score_q;
      return rep;
   endfunction

   function automatic logic [SAMPLE_W-1:0] clip16(int v);
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic cfg_type random_settings();
      cfg_type s;
      int      i;
      s.shake_thr   = THR_W'($urandom_range(120, 400));
      s.strong_thr  = THR_W'($urandom_range(300, 900));
      s.quiet_thr   = THR_W'($urandom_range(30, 150));
      s.start_score = SCORE_W'($urandom_range(1, 6));
      s.max_score   = SCORE_W'($urandom_range(4, 15));
      s.stop_quiet  = COUNT_W'($urandom_range(1, 12));
      s.warmup      = COUNT_W'($urandom_range(0, 10));
      for (i = 0; i < WEIGHTS_W / WEIGHT_W; i++)
         s.weights[WEIGHT_W*i +: WEIGHT_W] =
            ($urandom_range(0, 3) == 0) ? 8'd0 : WEIGHT_W'($urandom_range(1, 255));
      return s;
   endfunction

   // One APB transfer; the bus returns to idle after it, which keeps each access on its own edges
   task automatic csr_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_registers();
      logic [CSR_DATA_W-1:0] rd;
      int                    i;
      for (i = 0; i < REG_COUNT; i++) begin
         csr_access(1'b0, REG_IDX_W'(i), '0, rd);
         if (rd !== cfg_field(model_cfg, REG_IDX_W'(i))) begin
            $error("csr_prdata reg %0d: expected %h, got %h", i,
                   cfg_field(model_cfg, REG_IDX_W'(i)), rd);
            fail_count++;
         end
      end
   endtask

   // Write every register, with junk above each field's width, then read back
   task automatic load_settings(input cfg_type s);
      logic [CSR_DATA_W-1:0] junk;
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] rd;
      int                    i;
      for (i = 0; i < REG_COUNT; i++) begin
         junk = {$urandom, $urandom};
         wdata = cfg_field(s, REG_IDX_W'(i)) | (junk & ~cfg_field('1, REG_IDX_W'(i)));
         csr_access(1'b1, REG_IDX_W'(i), wdata, rd);
         apply_register(REG_IDX_W'(i), wdata);
      end
      check_registers();
   endtask

   // Offer one sample word; pace in bursts, hold valid until taken, then predict
   task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                              input logic [SAMPLE_W-1:0] z, input logic typed,
                              input shake_report_type given);
      shake_report_type rep;
      int               gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: gap = 0;
            19:            gap = $urandom_range(20, 60);
            default:       gap = $urandom_range(1, 12);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_accel_x <= x;
      req_accel_y <= y;
      req_accel_z <= z;
      do @(posedge clock); while (req_ready !== 1'b1);
      rep = score_and_pick(x, y, z);
      pending_reports.push_back(typed ? given : rep);
   endtask

   // Shape motion: swings with reversals, still stretches, band drift, raw noise
   task automatic make_motion(output logic [SAMPLE_W-1:0] x, output logic [SAMPLE_W-1:0] y,
                              output logic [SAMPLE_W-1:0] z);
      int main_off;
      int side_off;
      int pick;
      if (motion_left == 0) begin
         pick = $urandom_range(0, 19);
         if (pick < 8) begin
            motion_mode = MOTION_SWING;
            motion_left = $urandom_range(4, 20);
            swing_on_y  = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
               0, 1, 2:       swing_amp = $urandom_range(100, 400);
               8:             swing_amp = $urandom_range(3000, 12000);
               9:             swing_amp = $urandom_range(20000, 32767);
               default:       swing_amp = $urandom_range(400, 3000);
            endcase
         end else if (pick < 15) begin
            motion_mode = MOTION_STILL;
            motion_left = $urandom_range(3, 30);
         end else if (pick < 17) begin
            motion_mode = MOTION_DRIFT;
            motion_left = $urandom_range(1, 8);
         end else begin
            motion_mode = MOTION_NOISE;
            motion_left = $urandom_range(1, 6);
         end
      end
      motion_left--;
      main_off = int'($urandom_range(0, 40)) - 20;
      side_off = int'($urandom_range(0, 40)) - 20;
      case (motion_mode)
         MOTION_SWING: begin
            // Mostly reverse; sometimes repeat the same sign
            if ($urandom_range(0, 6) != 0)
               swing_sign = -swing_sign;
            main_off += swing_sign * swing_amp;
            side_off += (($urandom_range(0, 1) == 1) ? 1 : -1) *
                        int'($urandom_range(0, swing_amp / 2));
         end
         MOTION_DRIFT:
            main_off += (($urandom_range(0, 1) == 1) ? 1 : -1) * int'($urandom_range(40, 260));
         default: ;
      endcase
      if (motion_mode == MOTION_NOISE) begin
         x = SAMPLE_W'($urandom);
         y = SAMPLE_W'($urandom);
      end else if (swing_on_y) begin
         x = clip16(base_x + side_off);
         y = clip16(base_y + main_off);
      end else begin
         x = clip16(base_x + main_off);
         y = clip16(base_y + side_off);
      end
      z = SAMPLE_W'($urandom);
   endtask

   task automatic run_motion(input int count);
      logic [SAMPLE_W-1:0] x, y, z;
      int                  k;
      for (k = 0; k < count; k++) begin
         make_motion(x, y, z);
         send_sample(x, y, z, 1'b0, ZERO_REPORT);
      end
   endtask

   // Drop valid and wait for every pending report to be matched
   task automatic drain_pending();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(input cfg_type s, input int count);
      drain_pending();
      load_settings(s);
      base_x = int'($urandom_range(0, 2400)) - 1200;
      base_y = int'($urandom_range(0, 2400)) - 1200;
      motion_left = 0;
      run_motion(count);
   endtask

   initial begin
      int row;
      reset_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_registers();

      // Directed table under reset settings
      for (row = 0; row < DIRECTED_COUNT; row++)
         send_sample(DIRECTED_ROWS[row].x, DIRECTED_ROWS[row].y, DIRECTED_ROWS[row].z,
                     DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].want);
      run_motion(300);

      // Fields: shake, strong, quiet, start, max, stop, warm-up, weights.
      // No weights, instant stop, low score ceiling
      run_phase('{16'd100, 16'd300, 16'd60, 4'd2, 4'd3, 8'd0, 8'd0, 56'd0}, 150);
      // Everything at its maximum
      run_phase('{16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 4'hF, 8'hFF, 8'hFF,
                  56'hFF_FFFF_FFFF_FFFF}, 320);
      // Everything at zero, one lot weighted
      run_phase('{16'd0, 16'd0, 16'd0, 4'd0, 4'd0, 8'd0, 8'd0, 56'h01_0000_0000_0000}, 120);
      run_phase(random_settings(), 150);
      run_phase(random_settings(), 110);

      drain_pending();
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("shake_detect_weighted_pick_top_tb: PASS");
      else
         $display("shake_detect_weighted_pick_top_tb: FAIL");
      $finish;
   end

endmodule

### shake_detect_weighted_pick_top.f
rtl/sdwp_pkg.sv
rtl/sdwp_csr.sv
rtl/sdwp_filter.sv
rtl/sdwp_moddiv.sv
rtl/shake_detect_weighted_pick_top.sv
bench/shake_detect_weighted_pick_top_tb.sv
